// ===== hw/rtl/rpe_pkg.sv =====
// Shared constants, tables and types for the rotary position embedding block.
package rpe_pkg;

  localparam int HeadDim = 64;
  localparam int HalfHead = HeadDim / 2;
  localparam int PairSelW = $clog2(HalfHead);
  localparam int ExpShift = $clog2(HeadDim * 16);
  localparam int StepW = 38;
  localparam int StepLoW = 19;
  localparam int SincosLat = 8;
  localparam int FrontLat = 3;
  localparam int PipeDepth = FrontLat + SincosLat;

  localparam longint unsigned Q30One = 64'd1073741824;
  localparam longint unsigned Log2TenK = 64'd870824;
  localparam longint unsigned InvTwoPi = 64'd683565276;
  localparam longint unsigned HalfPi = 64'd1686629713;
  localparam longint unsigned Recip6 = 64'd2796203;

  localparam logic [12:0] LimitReset = 13'd4096;

  typedef logic [StepW-1:0] step_tbl_t [HalfHead];

  typedef struct packed {
    logic signed [15:0] q0;
    logic signed [15:0] q1;
    logic signed [15:0] k0;
    logic signed [15:0] k1;
    logic               rot;
  } item_t;

  function automatic longint unsigned exp2_rom(input int j);
    longint unsigned v;
    unique case (j)
      0:  v = 64'd759250125;
      1:  v = 64'd902905651;
      2:  v = 64'd984625594;
      3:  v = 64'd1028218693;
      4:  v = 64'd1050733751;
      5:  v = 64'd1062175491;
      6:  v = 64'd1067942999;
      7:  v = 64'd1070838486;
      8:  v = 64'd1072289173;
      9:  v = 64'd1073015252;
      10: v = 64'd1073378477;
      default: v = 64'd1073560135;
    endcase
    return v;
  endfunction

  function automatic step_tbl_t build_steps();
    step_tbl_t t;
    longint unsigned m, y, n, f, mant;
    for (int i = 0; i < HalfHead; i++) begin
      m = longint'(2 * i);
      y = (m * Log2TenK) >> ExpShift;
      n = y >> 12;
      f = y & 64'd4095;
      mant = Q30One;
      for (int j = 0; j < 12; j++) begin
        if (((f >> (11 - j)) & 64'd1) != 0)
          mant = (mant * exp2_rom(j) + (64'd1 << 29)) >> 30;
      end
      if (n > 40) n = 40;
      t[i] = StepW'((mant * InvTwoPi) >> (22 + n));
    end
    return t;
  endfunction

  localparam step_tbl_t StepTable = build_steps();

  function automatic logic [30:0] sine_rom(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd0;
      5'd1:  v = 31'd105245103;
      5'd2:  v = 31'd209476638;
      5'd3:  v = 31'd311690799;
      5'd4:  v = 31'd410903207;
      5'd5:  v = 31'd506158392;
      5'd6:  v = 31'd596538995;
      5'd7:  v = 31'd681174602;
      5'd8:  v = 31'd759250125;
      5'd9:  v = 31'd830013654;
      5'd10: v = 31'd892783698;
      5'd11: v = 31'd946955747;
      5'd12: v = 31'd992008094;
      5'd13: v = 31'd1027506862;
      5'd14: v = 31'd1053110176;
      5'd15: v = 31'd1068571464;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd32767) return 16'sh7fff;
    else if (t < -34'sd32768) return 16'sh8000;
    else return t[15:0];
  endfunction

endpackage

// ===== hw/rtl/rotary_position_embed_top.sv =====
// Top level of the rotary position embedding pipeline.
// One item is taken every clock cycle; busy stays low. The result of an item shows on the
// output ports with done high, after the item passes through the register stages in order:
// the phase stages (frequency table and position product), the sine and cosine stages, and
// the rotate and saturate stages. The receiver cannot stall the block.
// Write key_rotate_limit over the cfg channel (always ready) only while no item is in flight.
module rotary_position_embed_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [10:0]        pair_index,
  input  logic [12:0]        position,
  input  logic signed [15:0] query_first,
  input  logic signed [15:0] query_second,
  input  logic signed [15:0] key_first,
  input  logic signed [15:0] key_second,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] query_first_out,
  output logic signed [15:0] query_second_out,
  output logic signed [15:0] key_first_out,
  output logic signed [15:0] key_second_out,
  output logic               key_was_rotated
);

  localparam int Depth = rpe_pkg::PipeDepth;

  logic [12:0]                  limit;
  logic [Depth-1:0]             vld;
  rpe_pkg::item_t               pipe [Depth];
  logic [rpe_pkg::StepW-1:0]    step_s1;
  logic [12:0]                  pos_s1;
  logic [31:0]                  mlo_s2, mhi_s2;
  logic [50:0]                  full;
  logic [31:0]                  phase_s3;
  logic signed [15:0]           sin_val, cos_val;
  logic                         vld_r1;
  rpe_pkg::item_t               item_r1;
  logic signed [31:0]           q0c, q1s, q0s, q1c, k0c, k1s, k0s, k1c;
  rpe_pkg::item_t               item_in;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign item_in.q0  = query_first;
  assign item_in.q1  = query_second;
  assign item_in.k0  = key_first;
  assign item_in.k1  = key_second;
  assign item_in.rot = ({1'b0, pair_index, 1'b0} < limit);

  assign full = {mhi_s2, 19'b0} + 51'(mlo_s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= rpe_pkg::LimitReset;
      vld    <= '0;
      vld_r1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit <= cfg_data;
      vld    <= {vld[Depth-2:0], start && !busy};
      vld_r1 <= vld[Depth-1];
      done   <= vld_r1;
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= item_in;
    for (int i = 1; i < Depth; i++) pipe[i] <= pipe[i-1];
    step_s1  <= rpe_pkg::StepTable[pair_index[rpe_pkg::PairSelW-1:0]];
    pos_s1   <= position;
    mlo_s2   <= 32'(pos_s1) * 32'(step_s1[rpe_pkg::StepLoW-1:0]);
    mhi_s2   <= 32'(pos_s1) * 32'(step_s1[rpe_pkg::StepW-1:rpe_pkg::StepLoW]);
    phase_s3 <= full[39:8];

    item_r1 <= pipe[Depth-1];
    q0c <= pipe[Depth-1].q0 * cos_val;
    q1s <= pipe[Depth-1].q1 * sin_val;
    q0s <= pipe[Depth-1].q0 * sin_val;
    q1c <= pipe[Depth-1].q1 * cos_val;
    k0c <= pipe[Depth-1].k0 * cos_val;
    k1s <= pipe[Depth-1].k1 * sin_val;
    k0s <= pipe[Depth-1].k0 * sin_val;
    k1c <= pipe[Depth-1].k1 * cos_val;

    query_first_out  <= rpe_pkg::round_sat(34'(q0c) - 34'(q1s));
    query_second_out <= rpe_pkg::round_sat(34'(q0s) + 34'(q1c));
    if (item_r1.rot) begin
      key_first_out  <= rpe_pkg::round_sat(34'(k0c) - 34'(k1s));
      key_second_out <= rpe_pkg::round_sat(34'(k0s) + 34'(k1c));
    end else begin
      key_first_out  <= item_r1.k0;
      key_second_out <= item_r1.k1;
    end
    key_was_rotated <= item_r1.rot;
  end

  rpe_sincos u_sincos (
    .clk     (clk),
    .phase   (phase_s3),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

endmodule

// ===== hw/rtl/rpe_sincos.sv =====
// Pipelined sine and cosine of a Q32 phase in turns, Q14 outputs.
module rpe_sincos (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [15:0] sin_val,
  output logic signed [15:0] cos_val
);

  localparam logic [15:0] HpLo = 16'(rpe_pkg::HalfPi);
  localparam logic [14:0] HpHi = 15'(rpe_pkg::HalfPi >> 16);
  localparam logic [30:0] One30 = 31'(rpe_pkg::Q30One);
  localparam logic [21:0] Rcp6 = 22'(rpe_pkg::Recip6);

  logic [1:0]  quad_a, quad_b, quad_c, quad_d, quad_e, quad_f, quad_g;
  logic [3:0]  k_a, k_b, k_c, k_d, k_e;
  logic [41:0] pl_a;
  logic [40:0] ph_a;
  logic [26:0] b_b, b_c, b_d;
  logic [23:0] b2_c;
  logic [20:0] b3_d;
  logic [30:0] cb_d, cb_e;
  logic [26:0] sb_e;
  logic [61:0] ps1_f, ps2_f, pa_f, pb_f;
  logic [32:0] s_g, c_g;
  logic [56:0] bsum;
  logic [53:0] b2_prod;
  logic [50:0] b3_prod;
  logic [42:0] q6_prod;
  logic [30:0] sk, ck;
  logic [62:0] s_sum;
  logic [61:0] c_diff;
  logic [14:0] s14, c14;

  function automatic logic [14:0] to_q14(input logic [32:0] x);
    logic [31:0] t;
    t = (x > 33'(One30)) ? 32'(One30) : x[31:0];
    t = t + 32'd32768;
    return t[30:16];
  endfunction

  assign bsum    = {ph_a, 16'b0} + 57'(pl_a);
  assign b2_prod = 54'(b_b) * 54'(b_b);
  assign b3_prod = 51'(b2_c) * 51'(b_c);
  assign q6_prod = 43'(b3_d) * 43'(Rcp6);
  assign sk      = rpe_pkg::sine_rom({1'b0, k_e});
  assign ck      = rpe_pkg::sine_rom(5'd16 - {1'b0, k_e});
  assign s_sum   = 63'(ps1_f) + 63'(ps2_f) + 63'(64'd1 << 29);
  assign c_diff  = pa_f - pb_f + 62'(64'd1 << 29);
  assign s14     = to_q14(s_g);
  assign c14     = to_q14(c_g);

  always_ff @(posedge clk) begin
    quad_a <= phase[31:30];
    k_a    <= phase[29:26];
    pl_a   <= 42'(phase[25:0]) * 42'(HpLo);
    ph_a   <= 41'(phase[25:0]) * 41'(HpHi);

    quad_b <= quad_a;
    k_b    <= k_a;
    b_b    <= bsum[56:30];

    quad_c <= quad_b;
    k_c    <= k_b;
    b_c    <= b_b;
    b2_c   <= b2_prod[53:30];

    quad_d <= quad_c;
    k_d    <= k_c;
    b_d    <= b_c;
    b3_d   <= b3_prod[50:30];
    cb_d   <= One30 - 31'(b2_c >> 1);

    quad_e <= quad_d;
    k_e    <= k_d;
    cb_e   <= cb_d;
    sb_e   <= b_d - 27'(q6_prod[42:24]);

    quad_f <= quad_e;
    ps1_f  <= 62'(sk) * 62'(cb_e);
    ps2_f  <= 62'(ck) * 62'(sb_e);
    pa_f   <= 62'(ck) * 62'(cb_e);
    pb_f   <= 62'(sk) * 62'(sb_e);

    quad_g <= quad_f;
    s_g    <= s_sum[62:30];
    c_g    <= (pa_f < pb_f) ? 33'd0 : 33'(c_diff[61:30]);

    unique case (quad_g)
      2'd0: begin
        sin_val <= $signed({1'b0, s14});
        cos_val <= $signed({1'b0, c14});
      end
      2'd1: begin
        sin_val <= $signed({1'b0, c14});
        cos_val <= -$signed({1'b0, s14});
      end
      2'd2: begin
        sin_val <= -$signed({1'b0, s14});
        cos_val <= -$signed({1'b0, c14});
      end
      default: begin
        sin_val <= -$signed({1'b0, c14});
        cos_val <= $signed({1'b0, s14});
      end
    endcase
  end

endmodule

// ===== hw/rtl/rpe_checker.sv =====
// Port-level checks for the rotary position embedding top level.
module rpe_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               cfg_ready,
  input logic               done,
  input logic signed [15:0] key_first,
  input logic signed [15:0] key_second,
  input logic signed [15:0] key_first_out,
  input logic signed [15:0] key_second_out,
  input logic               key_was_rotated
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##13 done) else $error("item result missing");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##13 !done) else $error("result without item");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    (done && !key_was_rotated) |->
      (key_first_out == $past(key_first, 13) && key_second_out == $past(key_second, 13)))
    else $error("key pass-through altered");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!busy && cfg_ready)) else $error("block not ready");

endmodule

bind rotary_position_embed_top rpe_checker u_rpe_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .cfg_ready       (cfg_ready),
  .done            (done),
  .key_first       (key_first),
  .key_second      (key_second),
  .key_first_out   (key_first_out),
  .key_second_out  (key_second_out),
  .key_was_rotated (key_was_rotated)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the rotary position embedding block.
`timescale 1ns / 1ps

class rope_scoreboard;
  logic [12:0] key_limit;
  logic [63:0] pending_rot[$];
  logic pending_rot_flag[$];
  int errors;
  int checked;

  function new();
    key_limit = 13'd4096;
    errors = 0;
    checked = 0;
  endfunction

  function automatic longint unsigned exp2_frac(int j);
    longint unsigned tbl [12] = '{
      64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
      64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
      64'd1072289173, 64'd1073015252, 64'd1073378477, 64'd1073560135};
    return tbl[j];
  endfunction

  function automatic longint unsigned sin_tbl(int i);
    longint unsigned tbl [17] = '{
      64'd0, 64'd105245103, 64'd209476638, 64'd311690799, 64'd410903207,
      64'd506158392, 64'd596538995, 64'd681174602, 64'd759250125,
      64'd830013654, 64'd892783698, 64'd946955747, 64'd992008094,
      64'd1027506862, 64'd1053110176, 64'd1068571464, 64'd1073741824};
    return tbl[i];
  endfunction

  function automatic logic [31:0] angle_turns(longint unsigned elem, longint unsigned pos);
    longint unsigned m, y, n, f, mant, stp;
    m = elem % 64;
    y = (m * 64'd870824) / (64 * 16);
    n = y >> 12;
    f = y & 64'd4095;
    mant = 64'd1073741824;
    for (int j = 0; j < 12; j++)
      if (((f >> (11 - j)) & 1) != 0) mant = (mant * exp2_frac(j) + (64'd1 << 29)) >> 30;
    if (n > 40) n = 40;
    stp = (mant * 64'd683565276) >> (22 + n);
    return 32'((pos * stp) >> 8);
  endfunction

  function automatic longint q14(longint unsigned x);
    if (x > 64'd1073741824) x = 64'd1073741824;
    return longint'((x + 64'd32768) >> 16);
  endfunction

  function automatic logic [15:0] round_sat16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic [63:0] rotate_pair(logic [10:0] pidx, logic [12:0] pos,
      logic signed [15:0] q0, logic signed [15:0] q1,
      logic signed [15:0] k0, logic signed [15:0] k1, output logic rot);
    longint unsigned elem, g, b, b2, b3, sb, cb, sk, ck, s, c, pa, pb;
    logic [31:0] ph;
    longint s14, c14, sn, cs;
    logic [15:0] o0, o1, o2, o3;
    int k;
    elem = 2 * longint'(pidx);
    o0 = q0; o1 = q1; o2 = k0; o3 = k1; rot = 1'b0;
    if (elem < 4096) begin
      ph = angle_turns(elem, longint'(pos));
      k = ph[29:26];
      g = ph[25:0];
      b = (g * 64'd1686629713) >> 30;
      b2 = (b * b) >> 30;
      b3 = (b2 * b) >> 30;
      sb = b - b3 / 6;
      cb = 64'd1073741824 - (b2 >> 1);
      sk = sin_tbl(k);
      ck = sin_tbl(16 - k);
      s = (sk * cb + ck * sb + (64'd1 << 29)) >> 30;
      pa = ck * cb;
      pb = sk * sb;
      c = (pa < pb) ? 0 : ((pa - pb + (64'd1 << 29)) >> 30);
      s14 = q14(s);
      c14 = q14(c);
      case (ph[31:30])
        2'd0: begin sn = s14; cs = c14; end
        2'd1: begin sn = c14; cs = -s14; end
        2'd2: begin sn = -s14; cs = -c14; end
        default: begin sn = -c14; cs = s14; end
      endcase
      o0 = round_sat16(longint'(q0) * cs - longint'(q1) * sn);
      o1 = round_sat16(longint'(q0) * sn + longint'(q1) * cs);
      if (elem < longint'(key_limit)) begin
        o2 = round_sat16(longint'(k0) * cs - longint'(k1) * sn);
        o3 = round_sat16(longint'(k0) * sn + longint'(k1) * cs);
        rot = 1'b1;
      end
    end
    return {o0, o1, o2, o3};
  endfunction

  function void note_item(logic [10:0] pidx, logic [12:0] pos, logic [15:0] q0,
      logic [15:0] q1, logic [15:0] k0, logic [15:0] k1);
    logic r;
    logic [63:0] v;
    v = rotate_pair(pidx, pos, q0, q1, k0, k1, r);
    pending_rot.push_back(v);
    pending_rot_flag.push_back(r);
  endfunction

  function void check_result(logic [15:0] q0, logic [15:0] q1, logic [15:0] k0,
      logic [15:0] k1, logic r);
    logic [63:0] e;
    logic er;
    if (pending_rot.size() == 0) begin
      $display("%0t: unexpected result q=%h/%h k=%h/%h", $time, q0, q1, k0, k1);
      errors++;
      return;
    end
    e = pending_rot.pop_front();
    er = pending_rot_flag.pop_front();
    checked++;
    if (e[63:48] !== q0) begin
      $display("%0t: query_first_out exp %h got %h", $time, e[63:48], q0); errors++;
    end
    if (e[47:32] !== q1) begin
      $display("%0t: query_second_out exp %h got %h", $time, e[47:32], q1); errors++;
    end
    if (e[31:16] !== k0) begin
      $display("%0t: key_first_out exp %h got %h", $time, e[31:16], k0); errors++;
    end
    if (e[15:0] !== k1) begin
      $display("%0t: key_second_out exp %h got %h", $time, e[15:0], k1); errors++;
    end
    if (er !== r) begin
      $display("%0t: key_was_rotated exp %b got %b", $time, er, r); errors++;
    end
  endfunction
endclass

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [10:0] pair_index = '0;
  logic [12:0] position = '0;
  logic signed [15:0] query_first = '0, query_second = '0, key_first = '0, key_second = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;
  logic done;
  logic signed [15:0] query_first_out, query_second_out, key_first_out, key_second_out;
  logic key_was_rotated;

  rope_scoreboard sb = new();
  int send_gap_pct;
  int items_sent;
  longint cycles = 0;

  rotary_position_embed_top u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(query_first_out, query_second_out, key_first_out, key_second_out,
                      key_was_rotated);
    if (!rst && start && !busy) begin
      sb.note_item(pair_index, position, query_first, query_second, key_first, key_second);
      items_sent++;
    end
  end

  task automatic send_item(logic [10:0] p, logic [12:0] pos, logic [15:0] a,
      logic [15:0] b, logic [15:0] c, logic [15:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pair_index <= p;
    position <= pos;
    query_first <= a;
    query_second <= b;
    key_first <= c;
    key_second <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_and_set_limit(logic [12:0] lim);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_rot.size() != 0) @(posedge clk);
    repeat (rpe_pkg::PipeDepth + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.key_limit = lim;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_items(int count);
    logic [10:0] p;
    for (int i = 0; i < count; i++) begin
      p = ($urandom_range(9) == 0) ? 11'($urandom_range(2047, 2048)) : 11'($urandom_range(2047));
      if ($urandom_range(9) == 0) p = 11'($urandom());
      send_item(p, 13'($urandom()), rand_val(), rand_val(), rand_val(), rand_val());
    end
  endtask

  initial begin
    logic [12:0] limits [6] = '{13'd0, 13'd8191, 13'd64, 13'd4095, 13'd2047, 13'd1};
    items_sent = 0;
    send_gap_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(11'd0, 13'd0, 16'h1000, 16'h0000, 16'h0000, 16'h1000);
    send_item(11'd0, 13'd8191, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_item(11'd1, 13'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_item(11'd31, 13'd8191, 16'h8000, 16'h7fff, 16'h1234, 16'hedcb);
    send_item(11'd32, 13'd4096, 16'h0800, 16'hf800, 16'h4000, 16'hc000);
    send_item(11'd2047, 13'd100, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_item(11'd2048 - 1, 13'd0, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    send_item(11'd2048 - 3, 13'd5, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    send_item(11'd2047 - 1024, 13'd7777, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(11'd1023, 13'd8191, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(11'd1024, 13'd3, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    send_item(11'd16, 13'd2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(11'd7, 13'd1234, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff);
    send_item(11'd2047, 13'd8191, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    foreach (limits[i]) begin
      drain_and_set_limit(limits[i]);
      send_item(11'd0, 13'd9, 16'h4000, 16'h2000, 16'h4000, 16'h2000);
      send_item(11'(limits[i] >> 1), 13'd300, 16'h4000, 16'h2000, 16'h4000, 16'h2000);
      send_item(11'((limits[i] + 1) >> 1), 13'd300, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_gap_pct = (i % 3 == 0) ? 15 : (i % 3 == 1) ? 48 : 0;
      random_items(140);
    end
    drain_and_set_limit(13'd4096);
    send_gap_pct = 0;
    random_items(60);

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_rot.size() != 0) @(posedge clk);
    repeat (rpe_pkg::PipeDepth + 4) @(posedge clk);
    $display("Sent %0d items, checked %0d results over %0d key limit settings.",
             items_sent, sb.checked, 8);
    if (sb.errors == 0 && sb.pending_rot.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
